@@ hdl/cdeq_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cdeq_pkg
// shared types and constants for the circular deque with end match
// ---------------------------------------------------------------------------
package cdeq_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 2;
    localparam int S_DATA_W  = 8;
    localparam int S_USER_W  = MODE_W;
    localparam int M_USER_W  = STAT_W + 1;
    localparam int M_RAW_W   = 4 * CHAR_W + CAP_W;
    localparam int M_DATA_W  = ((M_RAW_W + 7) / 8) * 8;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RESET = (64 < DEPTH) ? 64 : DEPTH;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic               end_match;
        logic [CHAR_W-1:0]  popped_value;
        logic [CHAR_W-1:0]  opposite_value;
        logic [CHAR_W-1:0]  front_value;
        logic [CHAR_W-1:0]  rear_value;
        logic [CAP_W-1:0]   entry_count;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/circular_deque_with_end_match_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// circular_deque_with_end_match_top
// circular double-ended queue of characters with an end-match flag
// push, refused operation or pop of the last entry: result registered straight
//   to the output; any other pop first reads the new end in ST_READ (slot ram)
// throughput: one push per cycle unless the output stalls; no new request in ST_READ
// reset: queue empty, capacity 64, slot ram contents not cleared
// ---------------------------------------------------------------------------
module circular_deque_with_end_match_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cdeq_pkg::CAP_W-1:0]      i_cfg_wdata,     // capacity_in_use
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [cdeq_pkg::S_DATA_W-1:0]   i_s_axis_tdata,  // value
    input  wire logic [cdeq_pkg::S_USER_W-1:0]   i_s_axis_tuser,  // mode
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // popped_value, opposite_value, front_value, rear_value, entry_count, pad
    output logic      [cdeq_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    output logic      [cdeq_pkg::M_USER_W-1:0]   o_m_axis_tuser   // status, end_match
);

    import cdeq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_front_idx, n_front_idx;
    logic [ADDR_W-1:0]  r_rear_idx, n_rear_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cap, n_cap;
    logic [CHAR_W-1:0]  r_front_val, n_front_val;
    logic [CHAR_W-1:0]  r_rear_val, n_rear_val;
    logic               r_pend_front, n_pend_front;
    logic [CHAR_W-1:0]  r_pend_val, n_pend_val;
    logic               r_ov, n_ov;
    t_result            r_res, n_res;

    logic               accept;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [CHAR_W-1:0]  mem_wdata, mem_rdata;
    logic [CHAR_W-1:0]  value;
    t_status            res_status;
    logic               res_match;
    logic [CHAR_W-1:0]  res_popped, res_opp;
    logic               res_load;
    logic [ADDR_W-1:0]  idx_inc_front, idx_dec_front, idx_inc_rear, idx_dec_rear;
    logic [CMP_W-1:0]   cfg_ext;

    cdeq_slot_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CHAR_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_ov || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign value           = i_s_axis_tdata[CHAR_W-1:0];

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = M_DATA_W'({r_res.entry_count, r_res.rear_value,
                                        r_res.front_value, r_res.opposite_value,
                                        r_res.popped_value});
    assign o_m_axis_tuser  = {r_res.end_match, r_res.status};

    // ring index steps at the configured wrap point
    assign idx_inc_front = (CNT_W'(r_front_idx) + CNT_W'(1) >= r_cap) ? '0
                           : r_front_idx + ADDR_W'(1);
    assign idx_dec_front = (r_front_idx == '0) ? ADDR_W'(r_cap - CNT_W'(1))
                           : r_front_idx - ADDR_W'(1);
    assign idx_inc_rear  = (CNT_W'(r_rear_idx) + CNT_W'(1) >= r_cap) ? '0
                           : r_rear_idx + ADDR_W'(1);
    assign idx_dec_rear  = (r_rear_idx == '0) ? ADDR_W'(r_cap - CNT_W'(1))
                           : r_rear_idx - ADDR_W'(1);

    assign cfg_ext = CMP_W'(i_cfg_wdata);

    always_comb begin
        n_state      = r_state;
        n_front_idx  = r_front_idx;
        n_rear_idx   = r_rear_idx;
        n_count      = r_count;
        n_cap        = r_cap;
        n_front_val  = r_front_val;
        n_rear_val   = r_rear_val;
        n_pend_front = r_pend_front;
        n_pend_val   = r_pend_val;
        n_ov         = r_ov && !i_m_axis_tready;
        n_res        = r_res;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = value;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        res_status   = STAT_DONE;
        res_match    = 1'b0;
        res_popped   = '0;
        res_opp      = '0;
        res_load     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    res_load = 1'b1;
                    case (t_mode'(i_s_axis_tuser))
                        MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                            if (r_count >= r_cap) begin
                                res_status = STAT_FULL;
                            end else if (r_count == '0) begin
                                mem_we      = 1'b1;
                                mem_waddr   = '0;
                                n_front_idx = '0;
                                n_rear_idx  = '0;
                                n_front_val = value;
                                n_rear_val  = value;
                                n_count     = r_count + CNT_W'(1);
                            end else if (t_mode'(i_s_axis_tuser) == MODE_PUSH_FRONT) begin
                                res_opp     = r_rear_val;
                                res_match   = (r_rear_val == value);
                                mem_we      = 1'b1;
                                mem_waddr   = idx_dec_front;
                                n_front_idx = idx_dec_front;
                                n_front_val = value;
                                n_count     = r_count + CNT_W'(1);
                            end else begin
                                res_opp     = r_front_val;
                                res_match   = (r_front_val == value);
                                mem_we      = 1'b1;
                                mem_waddr   = idx_inc_rear;
                                n_rear_idx  = idx_inc_rear;
                                n_rear_val  = value;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_REAR: begin
                            if (r_count == '0) begin
                                res_status = STAT_EMPTY;
                            end else if (r_count == CNT_W'(1)) begin
                                res_popped  = r_front_val;
                                n_front_idx = '0;
                                n_rear_idx  = '0;
                                n_front_val = '0;
                                n_rear_val  = '0;
                                n_count     = '0;
                            end else if (t_mode'(i_s_axis_tuser) == MODE_POP_FRONT) begin
                                res_load     = 1'b0;
                                n_pend_front = 1'b1;
                                n_pend_val   = r_front_val;
                                mem_re       = 1'b1;
                                mem_raddr    = idx_inc_front;
                                n_front_idx  = idx_inc_front;
                                n_count      = r_count - CNT_W'(1);
                                n_state      = ST_READ;
                            end else begin
                                res_load     = 1'b0;
                                n_pend_front = 1'b0;
                                n_pend_val   = r_rear_val;
                                mem_re       = 1'b1;
                                mem_raddr    = idx_dec_rear;
                                n_rear_idx   = idx_dec_rear;
                                n_count      = r_count - CNT_W'(1);
                                n_state      = ST_READ;
                            end
                        end
                        default: begin
                            res_status = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_load   = 1'b1;
                res_popped = r_pend_val;
                if (r_pend_front) begin
                    n_front_val = mem_rdata;
                end else begin
                    n_rear_val = mem_rdata;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (res_load) begin
            n_ov                 = 1'b1;
            n_res.status         = res_status;
            n_res.end_match      = res_match;
            n_res.popped_value   = res_popped;
            n_res.opposite_value = res_opp;
            n_res.front_value    = n_front_val;
            n_res.rear_value     = n_rear_val;
            n_res.entry_count    = CAP_W'(n_count);
        end

        if (i_cfg_we) begin
            if (cfg_ext == '0) begin
                n_cap = CNT_W'(1);
            end else if (cfg_ext > CMP_W'(DEPTH)) begin
                n_cap = CNT_W'(DEPTH);
            end else begin
                n_cap = CNT_W'(cfg_ext);
            end
            n_count     = '0;
            n_front_idx = '0;
            n_rear_idx  = '0;
            n_front_val = '0;
            n_rear_val  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front_idx <= '0;
            r_rear_idx  <= '0;
            r_count     <= '0;
            r_cap       <= CNT_W'(CAP_RESET);
            r_front_val <= '0;
            r_rear_val  <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front_idx <= n_front_idx;
            r_rear_idx  <= n_rear_idx;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_front_val <= n_front_val;
            r_rear_val  <= n_rear_val;
            r_ov        <= n_ov;
        end
        r_pend_front <= n_pend_front;
        r_pend_val   <= n_pend_val;
        r_res        <= n_res;
    end

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front_idx == '0 && r_rear_idx == '0 &&
                             r_front_val == '0 && r_rear_val == '0))
        else $error("empty deque with stale ends");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_ov)
        else $error("pop result would overwrite pending transaction");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && mem_re) |=> (r_state == ST_READ))
        else $error("slot read issued without read state");

endmodule
`default_nettype wire

@@ hdl/cdeq_slot_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cdeq_slot_ram
// single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module cdeq_slot_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire
